// ===== rtl/dgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgd_pkg
// Shared types, constants and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
package dgd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned DNUM_W  = 23;   // day number from 1 Jan of year 0
  localparam int unsigned QUO_W   = 8;    // year / 100 for 14-bit years
  localparam int unsigned CUM_W   = 9;    // days before a month start

  // year / 100 == (year * RECIP_100) >> RECIP_SHIFT for years below 43699
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic load_en;    // capture the input transaction
    logic date_sel;   // 0: start date, 1: end date
    logic qy_en;      // register year / 100
    logic qp_en;      // register (year - 1) / 100
    logic base_en;    // register leap flag, validity and year base
    logic dnum_en;    // register the day number of the selected date
    logic fin_en;     // register the result
  } cmd_t;

  // Length of a month; zero for codes that name no month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:           n = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:  n = 5'd30;
      MON_FEB:                             n = leap ? 5'd29 : 5'd28;
      default:                             n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [CUM_W-1:0] n;
    case (m)
      MON_JAN: n = 9'd0;
      MON_FEB: n = 9'd31;
      MON_MAR: n = 9'd59;
      MON_APR: n = 9'd90;
      MON_MAY: n = 9'd120;
      MON_JUN: n = 9'd151;
      MON_JUL: n = 9'd181;
      MON_AUG: n = 9'd212;
      MON_SEP: n = 9'd243;
      MON_OCT: n = 9'd273;
      MON_NOV: n = 9'd304;
      MON_DEC: n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > MON_FEB)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/gregorian_date_difference_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_days
// Days between two Gregorian dates, via day numbers of both dates.
// ----------------------------------------------------------------------------
// Sequence: each date takes four steps, two of them through the shared
// divide-by-100 multiplier, then one step forms the difference, the
// result is handed over and the sequencer returns to idle for the next.
// The result holds until taken; in_tready is low from acceptance until
// the sequencer is idle again, so a new transaction is not taken before
// the previous result has been handed over.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
module gregorian_date_difference_days (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9],
  // end_day[27:23], end_month[31:28], end_year[45:32], zero fill [47:46]
  input  logic [47:0] in_tdata,
  // include_end_day[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day_count[21:0], zero fill [23:22]
  output logic [23:0] out_tdata,
  // invalid_date[0]
  output logic [0:0]  out_tuser
);

  dgd_pkg::cmd_t                cmd;
  logic [dgd_pkg::COUNT_W-1:0]  day_count;
  logic                         invalid_date;

  dgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dgd_datapath u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .start_day       (in_tdata[4:0]),
    .start_month     (in_tdata[8:5]),
    .start_year      (in_tdata[22:9]),
    .end_day         (in_tdata[27:23]),
    .end_month       (in_tdata[31:28]),
    .end_year        (in_tdata[45:32]),
    .include_end_day (in_tuser[0]),
    .day_count       (day_count),
    .invalid_date    (invalid_date)
  );

  assign out_tdata = {2'b00, day_count};
  assign out_tuser = invalid_date;

endmodule

// ===== rtl/dgd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgd_ctrl
// Sequencer: walks both dates through the datapath, then holds the result.
// ----------------------------------------------------------------------------
module dgd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output dgd_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_QY   = 7'b0000010,
    ST_QP   = 7'b0000100,
    ST_BASE = 7'b0001000,
    ST_DNUM = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   date_r, date_nxt;

  always_comb begin
    state_nxt = state_r;
    date_nxt  = date_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_QY;
          date_nxt  = 1'b0;
        end
      end
      ST_QY:   state_nxt = ST_QP;
      ST_QP:   state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_DNUM;
      ST_DNUM: begin
        // second pass for the end date
        if (!date_r) begin
          state_nxt = ST_QY;
          date_nxt  = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      date_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      date_r  <= date_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  always_comb begin
    cmd          = '0;
    cmd.load_en  = (state_r == ST_IDLE) && in_tvalid;
    cmd.date_sel = date_r;
    cmd.qy_en    = (state_r == ST_QY);
    cmd.qp_en    = (state_r == ST_QP);
    cmd.base_en  = (state_r == ST_BASE);
    cmd.dnum_en  = (state_r == ST_DNUM);
    cmd.fin_en   = (state_r == ST_FIN);
  end

endmodule

// ===== rtl/dgd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgd_datapath
// Day-number arithmetic with one shared divide-by-100 multiplier.
// ----------------------------------------------------------------------------
module dgd_datapath (
  input  logic                         clk,
  input  dgd_pkg::cmd_t                cmd,
  input  logic [dgd_pkg::DAY_W-1:0]    start_day,
  input  logic [dgd_pkg::MONTH_W-1:0]  start_month,
  input  logic [dgd_pkg::YEAR_W-1:0]   start_year,
  input  logic [dgd_pkg::DAY_W-1:0]    end_day,
  input  logic [dgd_pkg::MONTH_W-1:0]  end_month,
  input  logic [dgd_pkg::YEAR_W-1:0]   end_year,
  input  logic                         include_end_day,
  output logic [dgd_pkg::COUNT_W-1:0]  day_count,
  output logic                         invalid_date
);

  logic [dgd_pkg::DAY_W-1:0]   sd_r, ed_r;
  logic [dgd_pkg::MONTH_W-1:0] sm_r, em_r;
  logic [dgd_pkg::YEAR_W-1:0]  sy_r, ey_r;
  logic                        inc_r;

  logic [dgd_pkg::QUO_W-1:0]   qy_r, qp_r;
  logic                        leap_r, valid_r;
  logic [dgd_pkg::DNUM_W-1:0]  base_r;
  logic [dgd_pkg::DNUM_W-1:0]  dn_a_r, dn_b_r;
  logic                        va_r, vb_r;
  logic [dgd_pkg::COUNT_W-1:0] count_r;
  logic                        bad_r;

  // selected date
  logic [dgd_pkg::DAY_W-1:0]   cur_d;
  logic [dgd_pkg::MONTH_W-1:0] cur_m;
  logic [dgd_pkg::YEAR_W-1:0]  cur_y, cur_p;

  assign cur_d = cmd.date_sel ? ed_r : sd_r;
  assign cur_m = cmd.date_sel ? em_r : sm_r;
  assign cur_y = cmd.date_sel ? ey_r : sy_r;
  assign cur_p = cur_y - 14'd1;

  // shared reciprocal multiply: operand / 100
  logic [dgd_pkg::YEAR_W-1:0] mul_op;
  logic [dgd_pkg::PROD_W-1:0] prod;
  logic [dgd_pkg::QUO_W-1:0]  quo;

  assign mul_op = cmd.qp_en ? cur_p : cur_y;
  assign prod   = dgd_pkg::PROD_W'(mul_op) *
                  dgd_pkg::PROD_W'(dgd_pkg::RECIP_100);
  assign quo    = prod[dgd_pkg::RECIP_SHIFT +: dgd_pkg::QUO_W];

  // leap flag, validity and 365 * y + leap days before year y
  logic                        leap_nxt, valid_nxt;
  logic [dgd_pkg::DNUM_W-1:0]  base_nxt;
  logic [dgd_pkg::YEAR_W-1:0]  cent_y;
  logic [11:0]                 leaps;
  logic [dgd_pkg::DAY_W-1:0]   mdays;

  always_comb begin
    cent_y   = dgd_pkg::YEAR_W'(qy_r * 14'd100);
    leap_nxt = (cur_y[1:0] == 2'b00) && ((cur_y != cent_y) || (qy_r[1:0] == 2'b00));
    mdays    = dgd_pkg::month_days(cur_m, leap_nxt);
    valid_nxt = (cur_d != '0) && (cur_d <= mdays);
    if (cur_y == '0) begin
      leaps = '0;
    end else begin
      leaps = 12'd1 + 12'(cur_p >> 2) - 12'(qp_r) + 12'(qp_r >> 2);
    end
    base_nxt = dgd_pkg::DNUM_W'(cur_y) * 23'd365 + dgd_pkg::DNUM_W'(leaps);
  end

  logic [dgd_pkg::DNUM_W-1:0] dn_nxt;
  assign dn_nxt = base_r + dgd_pkg::DNUM_W'(dgd_pkg::days_before(cur_m, leap_r))
                + dgd_pkg::DNUM_W'(cur_d) - 23'd1;

  // final difference with saturation
  logic [dgd_pkg::DNUM_W-1:0]  diff, cnt;
  logic [dgd_pkg::COUNT_W-1:0] count_nxt;
  logic                        bad_nxt;

  always_comb begin
    diff = (dn_a_r < dn_b_r) ? (dn_b_r - dn_a_r) : '0;
    cnt  = diff + dgd_pkg::DNUM_W'(inc_r);
    bad_nxt = !(va_r && vb_r);
    if (bad_nxt) begin
      count_nxt = '0;
    end else if (cnt > dgd_pkg::DNUM_W'(dgd_pkg::COUNT_MAX)) begin
      count_nxt = dgd_pkg::COUNT_MAX;
    end else begin
      count_nxt = cnt[dgd_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      sd_r  <= start_day;
      sm_r  <= start_month;
      sy_r  <= start_year;
      ed_r  <= end_day;
      em_r  <= end_month;
      ey_r  <= end_year;
      inc_r <= include_end_day;
    end
    if (cmd.qy_en) begin
      qy_r <= quo;
    end
    if (cmd.qp_en) begin
      qp_r <= quo;
    end
    if (cmd.base_en) begin
      leap_r  <= leap_nxt;
      valid_r <= valid_nxt;
      base_r  <= base_nxt;
    end
    if (cmd.dnum_en) begin
      if (cmd.date_sel) begin
        dn_b_r <= dn_nxt;
        vb_r   <= valid_r;
      end else begin
        dn_a_r <= dn_nxt;
        va_r   <= valid_r;
      end
    end
    if (cmd.fin_en) begin
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign day_count    = count_r;
  assign invalid_date = bad_r;

endmodule
